>>> design/fnta_pkg.sv
// shared types, constants and control store for the number to ascii converter
`default_nettype none
package fnta_pkg;

	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned MAX_DIGITS = 16;

	localparam logic [1:0] MODE_UDEC = 2'd0;
	localparam logic [1:0] MODE_SDEC = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;
	localparam logic [1:0] MODE_BIN  = 2'd3;

	localparam logic [4:0] MAXD_UDEC = 5'd10;
	localparam logic [4:0] MAXD_SDEC = 5'd10;
	localparam logic [4:0] MAXD_HEX  = 5'd8;
	localparam logic [4:0] MAXD_BIN  = 5'd16;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_A     = 7'h41;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	// floor(v / 10) = (v * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit v
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int unsigned DIV10_SHIFT = 35;

	typedef logic [2:0] step_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_IN,
		C_NO_DIGITS,
		C_MORE_DIG,
		C_MORE_EMIT
	} cond_t;

	typedef struct packed {
		logic  load;
		logic  mul;
		logic  dig;
		logic  emit_sign;
		logic  emit_dig;
		cond_t cond;
		step_t target;
	} uword_t;

	localparam step_t ST_IDLE = 3'd0;
	localparam step_t ST_SIGN = 3'd1;
	localparam step_t ST_MUL  = 3'd2;
	localparam step_t ST_DIG  = 3'd3;
	localparam step_t ST_EMIT = 3'd4;
	localparam step_t ST_DONE = 3'd5;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{load: 1'b0, mul: 1'b0, dig: 1'b0, emit_sign: 1'b0, emit_dig: 1'b0,
			cond: C_ALWAYS, target: ST_IDLE};
		unique case (step)
			ST_IDLE: begin
				w.load   = 1'b1;
				w.cond   = C_NO_IN;
				w.target = ST_IDLE;
			end
			ST_SIGN: begin
				w.emit_sign = 1'b1;
				w.cond      = C_NO_DIGITS;
				w.target    = ST_IDLE;
			end
			ST_MUL: begin
				w.mul    = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = ST_DIG;
			end
			ST_DIG: begin
				w.dig    = 1'b1;
				w.cond   = C_MORE_DIG;
				w.target = ST_MUL;
			end
			ST_EMIT: begin
				w.emit_dig = 1'b1;
				w.cond     = C_MORE_EMIT;
				w.target   = ST_EMIT;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> design/fnta_in_if.sv
// input channel: number, digit count, line, start column and mode
`default_nettype none
interface fnta_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] value;
	logic [4:0]  digit_count;
	logic [2:0]  row;
	logic [4:0]  start_column;

	modport source (output valid, mode, value, digit_count, row, start_column, input ready);
	modport sink (input valid, mode, value, digit_count, row, start_column, output ready);
endinterface
`default_nettype wire

>>> design/fnta_out_if.sv
// output channel: one tagged ascii character per beat
`default_nettype none
interface fnta_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] out_row;
	logic [4:0] column;
	logic [6:0] char_code;
	logic       last;

	modport source (output valid, out_row, column, char_code, last, input ready);
	modport sink (input valid, out_row, column, char_code, last, output ready);
endinterface
`default_nettype wire

>>> design/fixed_width_number_to_ascii.sv
// fixed width number to ascii converter, microcoded digit sequencer
// sequence: a sign step after accept, then a multiply step and a digit step per digit through the
// shared reciprocal multiplier, then the emit step repeats per digit, most significant first
// a new number is accepted only in the load step, once the previous number is finished;
// the output register lets the final beat wait while the next number is loaded
// arst_n clears the step counter and output valid; payload registers are not reset
`default_nettype none
module fixed_width_number_to_ascii (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fnta_in_if.sink     din,
	fnta_out_if.source  dout
);

	fnta_pkg::step_t  pc_q;
	fnta_pkg::step_t  pc_d;
	fnta_pkg::uword_t uw;

	logic [31:0] val_q;
	logic [1:0]  mode_q;
	logic        neg_q;
	logic [2:0]  row_q;
	logic [4:0]  col_q;
	logic [4:0]  cnt_q;
	logic [4:0]  idx_q;
	logic [63:0] prod_q;
	logic [3:0]  digs_q [fnta_pkg::MAX_DIGITS];

	logic        out_valid_q;
	logic [2:0]  out_row_q;
	logic [4:0]  column_q;
	logic [6:0]  char_q;
	logic        last_q;

	logic        accept;
	logic        emit_sign_now;
	logic        emitting;
	logic        stall;
	logic        jmp;
	logic [4:0]  maxd;
	logic [4:0]  cnt_in;
	logic        neg_in;
	logic [31:0] mag_in;
	logic [28:0] quot;
	logic [31:0] quot10;
	logic [31:0] rem;
	logic [3:0]  dig;
	logic [31:0] val_next;
	logic [4:0]  rd_idx;
	logic [3:0]  emit_d;
	logic [6:0]  emit_char;

	assign uw            = fnta_pkg::ucode(pc_q);
	assign accept        = uw.load && din.valid;
	assign din.ready     = uw.load;
	assign emit_sign_now = uw.emit_sign && (mode_q == fnta_pkg::MODE_SDEC);
	assign emitting      = emit_sign_now || uw.emit_dig;
	assign stall         = emitting && out_valid_q && !dout.ready;

	// per mode digit limit
	always_comb begin
		unique case (din.mode)
			fnta_pkg::MODE_UDEC: maxd = fnta_pkg::MAXD_UDEC;
			fnta_pkg::MODE_SDEC: maxd = fnta_pkg::MAXD_SDEC;
			fnta_pkg::MODE_HEX:  maxd = fnta_pkg::MAXD_HEX;
			default:             maxd = fnta_pkg::MAXD_BIN;
		endcase
	end

	assign cnt_in = (din.digit_count > maxd) ? maxd : din.digit_count;
	assign neg_in = (din.mode == fnta_pkg::MODE_SDEC) && din.value[31];
	assign mag_in = neg_in ? (32'd0 - din.value) : din.value;

	// digit extraction
	assign quot   = prod_q[63:fnta_pkg::DIV10_SHIFT];
	assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem    = val_q - quot10;

	always_comb begin
		unique case (mode_q)
			fnta_pkg::MODE_HEX: begin
				dig      = val_q[3:0];
				val_next = {4'd0, val_q[31:4]};
			end
			fnta_pkg::MODE_BIN: begin
				dig      = {3'd0, val_q[0]};
				val_next = {1'b0, val_q[31:1]};
			end
			default: begin
				dig      = rem[3:0];
				val_next = {3'd0, quot};
			end
		endcase
	end

	assign rd_idx    = idx_q - 5'd1;
	assign emit_d    = digs_q[rd_idx[3:0]];
	assign emit_char = (emit_d < 4'd10) ? (fnta_pkg::CH_ZERO + {3'd0, emit_d})
		: (fnta_pkg::CH_A + {3'd0, emit_d} - 7'd10);

	// sequencer branch
	always_comb begin
		unique case (uw.cond)
			fnta_pkg::C_ALWAYS:    jmp = 1'b1;
			fnta_pkg::C_NO_IN:     jmp = !din.valid;
			fnta_pkg::C_NO_DIGITS: jmp = (cnt_q == 5'd0);
			fnta_pkg::C_MORE_DIG:  jmp = ((idx_q + 5'd1) < cnt_q);
			fnta_pkg::C_MORE_EMIT: jmp = (idx_q > 5'd1);
			default:               jmp = 1'b1;
		endcase
		if (stall) begin
			pc_d = pc_q;
		end else if (jmp) begin
			pc_d = uw.target;
		end else begin
			pc_d = pc_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= fnta_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			pc_q <= pc_d;
			if (emitting && !stall) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (uw.dig) begin
				idx_q <= idx_q + 5'd1;
			end else if (uw.emit_dig && !stall) begin
				idx_q <= idx_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= mag_in;
			mode_q <= din.mode;
			neg_q  <= neg_in;
			row_q  <= din.row;
			col_q  <= din.start_column;
			cnt_q  <= cnt_in;
		end
		if (uw.mul) begin
			prod_q <= 64'(val_q) * 64'(fnta_pkg::DIV10_RECIP);
		end
		if (uw.dig) begin
			digs_q[idx_q[3:0]] <= dig;
			val_q              <= val_next;
		end
		if (emitting && !stall) begin
			out_row_q <= row_q;
			column_q  <= col_q;
			col_q     <= col_q + 5'd1;
			if (emit_sign_now) begin
				char_q <= neg_q ? fnta_pkg::CH_MINUS : fnta_pkg::CH_PLUS;
				last_q <= (cnt_q == 5'd0);
			end else begin
				char_q <= emit_char;
				last_q <= (idx_q == 5'd1);
			end
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.out_row   = out_row_q;
	assign dout.column    = column_q;
	assign dout.char_code = char_q;
	assign dout.last      = last_q;

endmodule
`default_nettype wire

>>> design/fnta_chk.sv
// port level checks for the number to ascii converter, bound to the top level
`default_nettype none
module fnta_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] char_code,
	input wire logic       last
);

	// a stalled beat holds its character
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last))
		else $error("stalled output beat changed");

	// no new number right after one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// a number is still in flight after a non-final beat
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("input ready before the final beat");

	// only sign, digit or hex letter codes appear
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code >= 7'h30 && char_code <= 7'h39)
			|| (char_code >= 7'h41 && char_code <= 7'h46)
			|| char_code == 7'h2B || char_code == 7'h2D)
		else $error("illegal character code");

endmodule

bind fixed_width_number_to_ascii fnta_chk u_fnta_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.char_code (dout.char_code),
	.last      (dout.last)
);
`default_nettype wire

>>> tb/fixed_width_number_to_ascii_tb.sv
// self-checking testbench for the number to ascii converter, random stalls on both channels
`timescale 1ns / 100ps
module fixed_width_number_to_ascii_tb;

	localparam logic [4:0] DEC_LIMIT  = 5'd10;
	localparam logic [4:0] HEX_LIMIT  = 5'd8;
	localparam logic [4:0] BIN_LIMIT  = 5'd16;
	localparam int unsigned RANDOM_NUMBERS = 470;
	localparam int unsigned REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
		logic [4:0]  digit_count;
		logic [2:0]  row;
		logic [4:0]  start_column;
	} number_t;

	typedef struct packed {
		logic [2:0] row;
		logic [4:0] column;
		logic [6:0] code;
		logic       last;
	} char_beat_t;

	logic clk;
	logic arst_n;

	fnta_in_if  din();
	fnta_out_if dout();

	fixed_width_number_to_ascii dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.dout  (dout)
	);

	number_t     pending_numbers[$];
	char_beat_t  expected_chars[$];
	char_beat_t  want_char;
	int unsigned failures;
	int unsigned in_gap;
	int unsigned out_gap;
	bit          in_calm;
	bit          out_calm;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	// expected characters of one number, appended in output order
	function automatic void predict_chars(number_t n);
		logic [4:0]  limit;
		logic [4:0]  count;
		logic [31:0] mag;
		logic [3:0]  digs[16];
		logic        neg;
		int unsigned pos;
		char_beat_t  c;
		case (n.mode)
			fnta_pkg::MODE_HEX: limit = HEX_LIMIT;
			fnta_pkg::MODE_BIN: limit = BIN_LIMIT;
			default:            limit = DEC_LIMIT;
		endcase
		count = (n.digit_count > limit) ? limit : n.digit_count;
		mag = n.value;
		pos = 0;
		c.row = n.row;
		if (n.mode == fnta_pkg::MODE_SDEC) begin
			neg = mag[31];
			if (neg)
				mag = -mag;
			c.column = n.start_column;
			c.code = neg ? fnta_pkg::CH_MINUS : fnta_pkg::CH_PLUS;
			c.last = (count == 0);
			expected_chars.push_back(c);
			pos++;
		end
		for (int i = 0; i < count; i++) begin
			case (n.mode)
				fnta_pkg::MODE_HEX: digs[i] = 4'((mag >> (4 * i)) & 32'hF);
				fnta_pkg::MODE_BIN: digs[i] = 4'((mag >> i) & 32'h1);
				default: begin
					digs[i] = 4'(mag % 10);
					mag = mag / 10;
				end
			endcase
		end
		for (int i = 0; i < count; i++) begin
			c.column = 5'(n.start_column + pos);
			c.code = (digs[count - 1 - i] < 10)
				? fnta_pkg::CH_ZERO + 7'(digs[count - 1 - i])
				: fnta_pkg::CH_A + 7'(digs[count - 1 - i] - 10);
			c.last = (i + 1 == count);
			expected_chars.push_back(c);
			pos++;
		end
	endfunction

	task automatic add_number(input logic [1:0] mode, input logic [31:0] value,
		input logic [4:0] count, input logic [2:0] row, input logic [4:0] col);
		number_t n;
		n.mode = mode;
		n.value = value;
		n.digit_count = count;
		n.row = row;
		n.start_column = col;
		pending_numbers.push_back(n);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 1'b0;
			in_gap = 0;
			in_calm = 1'b0;
		end else begin
			if (din.valid && din.ready) begin
				predict_chars(pending_numbers.pop_front());
				in_gap = draw_gap(in_calm);
			end
			if (in_gap > 0) begin
				in_gap--;
				din.valid <= 1'b0;
			end else if (pending_numbers.size() > 0) begin
				din.valid <= 1'b1;
				din.mode <= pending_numbers[0].mode;
				din.value <= pending_numbers[0].value;
				din.digit_count <= pending_numbers[0].digit_count;
				din.row <= pending_numbers[0].row;
				din.start_column <= pending_numbers[0].start_column;
			end else begin
				din.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
			out_gap = 0;
			out_calm = 1'b0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (expected_chars.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("unexpected beat: row %0d column %0d char %h last %b",
							dout.out_row, dout.column, dout.char_code, dout.last);
				end else begin
					want_char = expected_chars.pop_front();
					if (dout.out_row !== want_char.row || dout.column !== want_char.column ||
						dout.char_code !== want_char.code || dout.last !== want_char.last) begin
						failures++;
						if (failures <= REPORT_LIMIT)
							$display({"mismatch: expected row %0d column %0d char %h last %b,",
								" got row %0d column %0d char %h last %b"},
								want_char.row, want_char.column, want_char.code, want_char.last,
								dout.out_row, dout.column, dout.char_code, dout.last);
					end
				end
				out_gap = draw_gap(out_calm);
			end
			if (out_gap > 0) begin
				out_gap--;
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= 1'b1;
			end
		end
	end

	initial begin
		number_t n;
		din.valid = 1'b0;
		din.mode = fnta_pkg::MODE_UDEC;
		din.value = '0;
		din.digit_count = '0;
		din.row = '0;
		din.start_column = '0;
		dout.ready = 1'b0;
		arst_n = 1'b0;
		failures = 0;

		// extremes, clamping, truncation, zero digit counts, column wrap
		add_number(fnta_pkg::MODE_UDEC, 32'd0, 5'd1, 3'd1, 5'd1);
		add_number(fnta_pkg::MODE_UDEC, 32'hFFFF_FFFF, 5'd10, 3'd4, 5'd16);
		add_number(fnta_pkg::MODE_UDEC, 32'd1234567890, 5'd31, 3'd2, 5'd0);
		add_number(fnta_pkg::MODE_UDEC, 32'd987654, 5'd3, 3'd3, 5'd5);
		add_number(fnta_pkg::MODE_UDEC, 32'd42, 5'd0, 3'd1, 5'd1);
		add_number(fnta_pkg::MODE_UDEC, 32'd7, 5'd16, 3'd7, 5'd31);
		add_number(fnta_pkg::MODE_SDEC, 32'h8000_0000, 5'd10, 3'd1, 5'd1);
		add_number(fnta_pkg::MODE_SDEC, 32'h7FFF_FFFF, 5'd16, 3'd2, 5'd20);
		add_number(fnta_pkg::MODE_SDEC, 32'hFFFF_FFFF, 5'd4, 3'd0, 5'd3);
		add_number(fnta_pkg::MODE_SDEC, 32'hFFFF_FFFB, 5'd0, 3'd3, 5'd9);
		add_number(fnta_pkg::MODE_SDEC, 32'd5, 5'd0, 3'd4, 5'd31);
		add_number(fnta_pkg::MODE_SDEC, 32'd0, 5'd1, 3'd5, 5'd30);
		add_number(fnta_pkg::MODE_SDEC, 32'h8000_0001, 5'd31, 3'd6, 5'd25);
		add_number(fnta_pkg::MODE_HEX, 32'hDEAD_BEEF, 5'd8, 3'd1, 5'd1);
		add_number(fnta_pkg::MODE_HEX, 32'hFFFF_FFFF, 5'd31, 3'd2, 5'd28);
		add_number(fnta_pkg::MODE_HEX, 32'h0123_ABCD, 5'd0, 3'd3, 5'd2);
		add_number(fnta_pkg::MODE_HEX, 32'h89AB_CDEF, 5'd3, 3'd4, 5'd14);
		add_number(fnta_pkg::MODE_HEX, 32'h0000_0000, 5'd9, 3'd7, 5'd0);
		add_number(fnta_pkg::MODE_BIN, 32'hAAAA_5555, 5'd16, 3'd1, 5'd1);
		add_number(fnta_pkg::MODE_BIN, 32'hFFFF_FFFF, 5'd31, 3'd4, 5'd17);
		add_number(fnta_pkg::MODE_BIN, 32'h0000_0001, 5'd0, 3'd2, 5'd4);
		add_number(fnta_pkg::MODE_BIN, 32'h0000_0000, 5'd1, 3'd3, 5'd31);
		add_number(fnta_pkg::MODE_BIN, 32'h5555_AAAA, 5'd17, 3'd0, 5'd16);

		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			n.mode = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: n.value = $urandom;
				1: n.value = $urandom_range(0, 999);
				2: n.value = $urandom >> $urandom_range(0, 31);
				default: begin
					case ($urandom_range(0, 7))
						0: n.value = 32'd0;
						1: n.value = 32'd9;
						2: n.value = 32'd1000000000;
						3: n.value = 32'd999999999;
						4: n.value = 32'h7FFF_FFFF;
						5: n.value = 32'h8000_0000;
						6: n.value = 32'h8000_0001;
						default: n.value = 32'hFFFF_FFFF;
					endcase
				end
			endcase
			n.digit_count = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(1, 16));
			n.row = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 4));
			n.start_column = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(1, 16));
			pending_numbers.push_back(n);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_numbers.size() == 0 && expected_chars.size() == 0);
		repeat (120) @(posedge clk);
		if (failures == 0)
			$display("fixed_width_number_to_ascii_tb OK");
		else
			$display("fixed_width_number_to_ascii_tb NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("fixed_width_number_to_ascii_tb NOT OK");
		$finish;
	end

endmodule
